[design/rtcm3v_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcm3v_pkg
// Shared types, codes and the CRC-24Q byte step for the RTCM3 frame validator.
// ----------------------------------------------------------------------------
package rtcm3v_pkg;

    localparam int FRAME_BUFFER_BYTES_DEF = 1030;

    localparam int POS_W = 11;   // frame positions and lengths
    localparam int FWD_W = 32;   // forwarded byte total
    localparam int CRC_W = 24;

    localparam logic [7:0]       PREAMBLE     = 8'hD3;
    localparam logic [7:0]       RSV_MASK     = 8'hFC;
    localparam logic [CRC_W-1:0] CRC_POLY     = 24'h864CFB; // x^24 term implied
    localparam logic [POS_W-1:0] HDR_OVERHEAD = 11'd6;      // preamble, header, CRC
    localparam logic [POS_W-1:0] CRC_BYTES    = 11'd3;

    // frame status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_CRC_BAD = 2'd2;
    localparam logic [1:0] ST_HDR_BAD = 2'd3;

    // output queue geometry
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] length;
        logic [FWD_W-1:0] fwd;
    } result_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] length;
        logic [7:0]       rdata;
        logic [FWD_W-1:0] fwd;
    } out_item_t;

    // One byte through CRC-24Q, MSB first, no reflection.
    function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[design/rtcm3v_frame_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcm3v_frame_ram
// Frame buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtcm3v_frame_ram #(
    parameter int DEPTH = rtcm3v_pkg::FRAME_BUFFER_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire rtcm3v_pkg::ram_wr_t wr,
    input  wire rtcm3v_pkg::ram_rd_t rd,
    output logic [7:0]               rd_data
);
    import rtcm3v_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr[AW-1:0]] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
            rd_data <= mem[rd.addr[AW-1:0]];
    end

endmodule
`default_nettype wire

[design/rtcm3v_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcm3v_parser
// Framing state machine, CRC-24Q accumulator, buffer port control and the
// result stage that lines up with the buffer read data.
// ----------------------------------------------------------------------------
module rtcm3v_parser #(
    parameter int FRAME_BUFFER_BYTES = rtcm3v_pkg::FRAME_BUFFER_BYTES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic                   operation,
    input  wire logic [7:0]             data_byte,
    input  wire logic [rtcm3v_pkg::POS_W-1:0] read_index,
    output rtcm3v_pkg::ram_wr_t         ram_wr,
    output rtcm3v_pkg::ram_rd_t         ram_rd,
    output logic                        res_valid,
    output logic                        res_rd_ok,
    output rtcm3v_pkg::result_t         res
);
    import rtcm3v_pkg::*;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HDR1 = 2'd1;
    localparam logic [1:0] PH_HDR2 = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    localparam logic [POS_W-1:0] BUF_BYTES = POS_W'(FRAME_BUFFER_BYTES);

    logic [1:0]       phase_reg,  phase_next;
    logic [POS_W-1:0] wp_reg,     wp_next;
    logic [POS_W-1:0] exp_reg,    exp_next;
    logic [CRC_W-1:0] crc_reg,    crc_next;
    logic [FWD_W-1:0] fwd_reg,    fwd_next;
    logic [1:0]       len_hi_reg, len_hi_next;
    logic [15:0]      tail_reg,   tail_next;

    logic             res_valid_reg;
    logic             rd_ok_reg;
    result_t          res_reg;

    logic [1:0]       status;
    logic [POS_W-1:0] flen;
    logic [9:0]       plen;
    logic [POS_W-1:0] total;
    logic [POS_W:0]   wp_plus_crc;
    logic [POS_W-1:0] wp_inc;

    always_comb
    begin
        phase_next  = phase_reg;
        wp_next     = wp_reg;
        exp_next    = exp_reg;
        crc_next    = crc_reg;
        fwd_next    = fwd_reg;
        len_hi_next = len_hi_reg;
        tail_next   = tail_reg;
        status      = ST_NONE;
        flen        = '0;
        ram_wr.en   = 1'b0;
        ram_wr.addr = wp_reg;
        ram_wr.data = data_byte;
        plen        = {len_hi_reg, data_byte};
        total       = POS_W'(plen) + HDR_OVERHEAD;
        wp_plus_crc = {1'b0, wp_reg} + {1'b0, CRC_BYTES};
        wp_inc      = wp_reg + 1'b1;

        if (accept && !operation)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (data_byte == PREAMBLE)
                    begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = '0;
                        wp_next     = POS_W'(1);
                        crc_next    = crc24q_byte('0, PREAMBLE);
                        phase_next  = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    if ((data_byte & RSV_MASK) != 8'h00)
                    begin
                        status = ST_HDR_BAD;
                        if (data_byte == PREAMBLE)
                        begin
                            // the bad header byte opens a fresh candidate
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = '0;
                            wp_next     = POS_W'(1);
                            crc_next    = crc24q_byte('0, PREAMBLE);
                            phase_next  = PH_HDR1;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                            wp_next    = '0;
                            exp_next   = '0;
                            crc_next   = '0;
                        end
                    end
                    else
                    begin
                        ram_wr.en   = 1'b1;
                        wp_next     = wp_inc;
                        crc_next    = crc24q_byte(crc_reg, data_byte);
                        len_hi_next = data_byte[1:0];
                        phase_next  = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    ram_wr.en = 1'b1;
                    if (plen == 10'd0 || total > BUF_BYTES)
                    begin
                        status     = ST_HDR_BAD;
                        phase_next = PH_WAIT;
                        wp_next    = '0;
                        exp_next   = '0;
                        crc_next   = '0;
                    end
                    else
                    begin
                        wp_next    = wp_inc;
                        crc_next   = crc24q_byte(crc_reg, data_byte);
                        exp_next   = total;
                        phase_next = PH_BODY;
                    end
                end
                default:
                begin
                    ram_wr.en = (wp_reg < BUF_BYTES);
                    tail_next = {tail_reg[7:0], data_byte};
                    wp_next   = wp_inc;
                    // CRC covers everything ahead of the three trailing bytes
                    if (wp_plus_crc < {1'b0, exp_reg})
                        crc_next = crc24q_byte(crc_reg, data_byte);
                    if (wp_inc >= exp_reg)
                    begin
                        flen = exp_reg;
                        if ({tail_reg, data_byte} == crc_reg)
                        begin
                            status   = ST_GOOD;
                            fwd_next = fwd_reg + FWD_W'(exp_reg);
                        end
                        else
                        begin
                            status = ST_CRC_BAD;
                        end
                        phase_next = PH_WAIT;
                        wp_next    = '0;
                        exp_next   = '0;
                        crc_next   = '0;
                    end
                end
            endcase
        end
    end

    // Reads and writes come from different beats, so one never meets the other
    // in the same cycle and the read sees every earlier write.
    always_comb
    begin
        ram_rd.en   = accept && operation && (read_index < BUF_BYTES);
        ram_rd.addr = read_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            wp_reg        <= '0;
            exp_reg       <= '0;
            crc_reg       <= '0;
            fwd_reg       <= '0;
            len_hi_reg    <= '0;
            tail_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            exp_reg       <= exp_next;
            crc_reg       <= crc_next;
            fwd_reg       <= fwd_next;
            len_hi_reg    <= len_hi_next;
            tail_reg      <= tail_next;
            res_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ok_reg      <= ram_rd.en;
            res_reg.status <= status;
            res_reg.length <= flen;
            res_reg.fwd    <= fwd_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_rd_ok = rd_ok_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_read_keeps_parser: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation) |=> ($stable(phase_reg) && $stable(wp_reg)))
        else $error("read beat disturbed the parser");

    a_body_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (exp_reg >= POS_W'(7) && wp_reg < exp_reg
                                    && exp_reg <= BUF_BYTES))
        else $error("body position outside the expected frame");

    a_fwd_only_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_reg != $past(fwd_reg)) |-> (res_valid_reg && res_reg.status == ST_GOOD))
        else $error("forwarded total moved without a good frame");
`endif

endmodule
`default_nettype wire

[design/rtcm3v_out_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcm3v_out_queue
// Small result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module rtcm3v_out_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire rtcm3v_pkg::out_item_t   push_item,
    input  wire logic                    pop,
    output rtcm3v_pkg::out_item_t        head,
    output logic                         not_empty,
    output logic [rtcm3v_pkg::OQ_CNT_W-1:0] count
);
    import rtcm3v_pkg::*;

    out_item_t            ent_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]  count_reg,  count_next;
    logic                 do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_item;
    end

    assign head      = ent_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < OQ_CNT_W'(OQ_DEPTH) || do_pop))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue count out of range");
`endif

endmodule
`default_nettype wire

[design/rtcm3_frame_validator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcm3_frame_validator
// RTCM3 framing and CRC-24Q check over a byte stream, with frame buffer reads.
// ----------------------------------------------------------------------------
// Push beats (tuser = 0) feed stream bytes to a hunter that locks on the 0xD3
// preamble, checks the six reserved header bits and the 10-bit length, stores
// the frame in an on-chip buffer and runs CRC-24Q one byte per beat. Every
// input beat yields exactly one output beat: status 1 marks a good frame and
// bumps the forwarded byte total by its length, status 2 a CRC mismatch, 3 a
// rejected header. Read beats (tuser = 1) return the buffered byte at
// read_index; the buffer holds the frame being or last parsed, over older
// bytes past its end, and a read outside the buffer returns zero. The block
// takes one beat per clock while tready is high, for pushes and reads alike:
// the buffer has one write and one read port and any beat uses at most one
// of them, and the CRC step is a single byte per cycle. Each result is
// registered with the buffer read data, then written into a three-entry
// result queue that keeps input flowing while the output side stalls; input
// tready drops only when that queue and the in-flight result would fill it.
// ----------------------------------------------------------------------------
module rtcm3_frame_validator #(
    parameter int FRAME_BUFFER_BYTES = rtcm3v_pkg::FRAME_BUFFER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [18:8] read_index, rest 0
    input  wire logic        s_axis_tuser,   // [0] operation (0 push, 1 read)
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [10:0] frame_length, [18:11] read_data,
                                             // [50:19] bytes_forwarded, rest 0
    output logic [1:0]       m_axis_tuser    // [1:0] frame_status
);
    import rtcm3v_pkg::*;

    logic                 accept;
    ram_wr_t              ram_wr;
    ram_rd_t              ram_rd;
    logic [7:0]           ram_q;
    logic                 res_valid;
    logic                 res_rd_ok;
    result_t              res;
    out_item_t            q_in;
    out_item_t            q_head;
    logic                 q_not_empty;
    logic [OQ_CNT_W-1:0]  q_count;
    logic [OQ_CNT_W:0]    occupancy;

    // Hold input while the queue plus the in-flight result could not take it.
    assign occupancy     = {1'b0, q_count} + {{OQ_CNT_W{1'b0}}, res_valid};
    assign s_axis_tready = (occupancy < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    rtcm3v_parser #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (s_axis_tuser),
        .data_byte  (s_axis_tdata[7:0]),
        .read_index (s_axis_tdata[18:8]),
        .ram_wr     (ram_wr),
        .ram_rd     (ram_rd),
        .res_valid  (res_valid),
        .res_rd_ok  (res_rd_ok),
        .res        (res)
    );

    rtcm3v_frame_ram #(
        .DEPTH(FRAME_BUFFER_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_q)
    );

    // Merge buffer read data into the result; out-of-range reads give zero.
    always_comb
    begin
        q_in.status = res.status;
        q_in.length = res.length;
        q_in.rdata  = res_rd_ok ? ram_q : 8'h00;
        q_in.fwd    = res.fwd;
    end

    rtcm3v_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (q_in),
        .pop       (m_axis_tready),
        .head      (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tuser  = q_head.status;
    assign m_axis_tdata  = {5'b00000, q_head.fwd, q_head.rdata, q_head.length};

endmodule
`default_nettype wire

[tb/tb_rtcm3_frame_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtcm3_frame_validator
// Self-checking bench for the RTCM3 framing and CRC-24Q validator.
// ----------------------------------------------------------------------------
// A short directed table hits the header corner cases, a minimal good frame,
// a minimal frame with a spoiled CRC and buffer reads at both ends of the
// index range. Random traffic follows: mostly well-formed frames with random
// payloads and occasional reads slipped in mid-frame, plus CRC errors, bad
// reserved bits, zero lengths, truncated frames, plain reads, line noise and
// one maximum-length frame. A behavioral parser predicts one report per
// accepted beat, and every output beat is checked against the oldest pending
// report. Both sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_rtcm3_frame_validator;

    import rtcm3v_pkg::*;

    localparam int BUF_BYTES    = FRAME_BUFFER_BYTES_DEF;
    localparam int ITEMS        = 1650;
    localparam int CALM_TAIL    = 200;   // last beats with no idling
    localparam int STALL_LIMIT  = 2000;  // cycles without any beat moving
    localparam int SETTLE_TICKS = 8;     // idle ticks after the last report

    // beat kinds carried on tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // parser phases of the behavioral model
    typedef enum logic [1:0] {PH_HUNT, PH_HDR_A, PH_HDR_B, PH_PAYLOAD} phase_t;

    // directed rows may take their byte from the running CRC of the model
    typedef enum logic [2:0] {
        FILL_NONE, FILL_CRC_HI, FILL_CRC_MID, FILL_CRC_LO, FILL_CRC_SPOIL
    } fill_t;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic [10:0] idx;
        fill_t      fill;
        logic       typed;   // use want below instead of the model
        out_item_t  want;
    } vec_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // [7:0] data_byte, [18:8] read_index, rest 0
    logic        s_axis_tuser;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;    // [10:0] frame_length, [18:11] read_data,
                                  // [50:19] bytes_forwarded, rest 0
    logic [1:0]  m_axis_tuser;    // [1:0] frame_status

    rtcm3_frame_validator #(
        .FRAME_BUFFER_BYTES (BUF_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Behavioral parser state
    // ------------------------------------------------------------------
    phase_t      phase;
    logic [7:0]  frame_copy [0:BUF_BYTES-1];
    int unsigned frame_fill;      // entries written so far, always from 0 up
    logic [10:0] wr_pos;
    logic [10:0] want_total;
    logic [23:0] crc_run;
    logic [31:0] fwd_total;

    out_item_t   expected_reports [$];
    int unsigned mismatch_cnt;

    // handoff from the sender: a typed expectation for the beat on the bus
    logic        row_typed;
    out_item_t   row_want;

    logic        wind_down;
    int unsigned beats_sent;
    int unsigned steady_left;
    logic [7:0]  frame_bytes [$];
    vec_t        directed_rows [$];

    // CRC-24Q, one byte MSB first, worked on a 25-bit register
    function automatic logic [23:0] crc24q_next(input logic [23:0] crc,
                                                input logic [7:0] b);
        logic [24:0] r;
        r = {1'b0, crc ^ {b, 16'h0000}};
        for (int i = 0; i < 8; i++)
        begin
            r = r << 1;
            if (r[24])
                r = r ^ 25'h1864CFB;
        end
        return r[23:0];
    endfunction

    function automatic logic [7:0] buf_at(input logic [10:0] idx);
        return (idx < BUF_BYTES) ? frame_copy[idx] : 8'h00;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        if (wr_pos < BUF_BYTES)
        begin
            frame_copy[wr_pos] = b;
            if (wr_pos + 1 > frame_fill)
                frame_fill = wr_pos + 1;
        end
        wr_pos = wr_pos + 11'd1;
    endtask

    task automatic go_hunt();
        phase      = PH_HUNT;
        wr_pos     = '0;
        want_total = '0;
        crc_run    = '0;
    endtask

    task automatic open_candidate();
        wr_pos = '0;
        put_byte(PREAMBLE);
        crc_run = crc24q_next(24'h000000, PREAMBLE);
        phase   = PH_HDR_A;
    endtask

    // Advance the parser by one accepted beat and return its report.
    task automatic advance_parser(input logic op, input logic [7:0] b,
                                  input logic [10:0] idx, output out_item_t rep);
        logic [7:0]  hdr;
        logic [9:0]  plen;
        logic [23:0] got_crc;
        rep = '0;
        if (op == OP_READ)
            rep.rdata = buf_at(idx);
        else
        begin
            case (phase)
                PH_HUNT:
                    if (b == PREAMBLE)
                        open_candidate();
                PH_HDR_A:
                    if ((b & RSV_MASK) != 8'h00)
                    begin
                        // a preamble here starts over rather than hunting
                        rep.status = ST_HDR_BAD;
                        if (b == PREAMBLE)
                            open_candidate();
                        else
                            go_hunt();
                    end
                    else
                    begin
                        put_byte(b);
                        crc_run = crc24q_next(crc_run, b);
                        phase   = PH_HDR_B;
                    end
                PH_HDR_B:
                begin
                    put_byte(b);
                    crc_run    = crc24q_next(crc_run, b);
                    hdr        = buf_at(11'd1);
                    plen       = {hdr[1:0], b};
                    want_total = {1'b0, plen} + HDR_OVERHEAD;
                    if (plen == 10'd0 || want_total > BUF_BYTES)
                    begin
                        rep.status = ST_HDR_BAD;
                        go_hunt();
                    end
                    else
                        phase = PH_PAYLOAD;
                end
                default:
                begin
                    // the trailing CRC bytes are stored but not folded in
                    if (int'(wr_pos) + int'(CRC_BYTES) < int'(want_total))
                        crc_run = crc24q_next(crc_run, b);
                    put_byte(b);
                    if (wr_pos >= want_total)
                    begin
                        got_crc = {buf_at(want_total - CRC_BYTES),
                                   buf_at(want_total - 11'd2),
                                   buf_at(want_total - 11'd1)};
                        rep.length = want_total;
                        if (got_crc == crc_run)
                        begin
                            rep.status = ST_GOOD;
                            fwd_total  = fwd_total + 32'(want_total);
                        end
                        else
                            rep.status = ST_CRC_BAD;
                        go_hunt();
                    end
                end
            endcase
        end
        rep.fwd = fwd_total;
    endtask

    task automatic flag_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t %s: want st=%0d len=%0d rd=%h fwd=%0d, got st=%0d len=%0d rd=%h fwd=%0d",
                     $time, what, want.status, want.length, want.rdata, want.fwd,
                     got.status, got.length, got.rdata, got.fwd);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scoreboard: check the output beat first, then log the input beat, so
    // both happen in a fixed order within the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        out_item_t seen;
        out_item_t want;
        out_item_t pred;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.status = m_axis_tuser;
                seen.length = m_axis_tdata[10:0];
                seen.rdata  = m_axis_tdata[18:11];
                seen.fwd    = m_axis_tdata[50:19];
                if (expected_reports.size() == 0)
                    flag_mismatch("unexpected beat", '0, seen);
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen.status != want.status || seen.length != want.length ||
                        seen.rdata != want.rdata || seen.fwd != want.fwd)
                        flag_mismatch("mismatch", want, seen);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_parser(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[18:8], pred);
                expected_reports.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when no beat moves on either side for too long.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_rtcm3_frame_validator: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side backpressure: random stall bursts between runs of ready,
    // with long steady runs now and then; hold ready high at the end.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        run_left      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (wind_down)
                stall_left = 0;
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (run_left != 0)
                    run_left--;
                else if (!wind_down)
                begin
                    if ($urandom_range(0, 2) == 0)
                        stall_left = $urandom_range(1, 13);
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(0, 8);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one beat and hold it until accepted. Entered and left at a
    // falling edge; may first drop valid for a random gap.
    task automatic push_beat(input logic op, input logic [7:0] b,
                             input logic [10:0] idx, input bit tally);
        if (!wind_down)
        begin
            if (steady_left != 0)
                steady_left--;
            else if ($urandom_range(0, 3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            else if ($urandom_range(0, 9) == 0)
                steady_left = $urandom_range(30, 120);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b00000, idx, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (tally)
            beats_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every pending report has come out.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_reports.size() != 0);
    endtask

    // Read only entries that were written, or past the end of the buffer.
    function automatic logic [10:0] pick_read_index();
        if (frame_fill == 0 || $urandom_range(0, 5) == 0)
            return 11'($urandom_range(BUF_BYTES, 2047));
        return 11'($urandom_range(0, frame_fill - 1));
    endfunction

    // Build a well-formed frame with a random payload in frame_bytes.
    task automatic make_frame(input logic [9:0] plen);
        logic [23:0] crc;
        frame_bytes.delete();
        frame_bytes.push_back(PREAMBLE);
        frame_bytes.push_back({6'b000000, plen[9:8]});
        frame_bytes.push_back(plen[7:0]);
        for (int i = 0; i < plen; i++)
            frame_bytes.push_back(($urandom_range(0, 7) == 0) ? PREAMBLE
                                                              : 8'($urandom_range(0, 255)));
        crc = '0;
        foreach (frame_bytes[i])
            crc = crc24q_next(crc, frame_bytes[i]);
        frame_bytes.push_back(crc[23:16]);
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
    endtask

    // Send the first upto bytes of frame_bytes, slipping in a read now and then.
    task automatic send_frame(input int upto);
        for (int i = 0; i < upto; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_beat(OP_READ, 8'($urandom_range(0, 255)), pick_read_index(), 1'b1);
            push_beat(OP_PUSH, frame_bytes[i], 11'($urandom_range(0, 2047)), 1'b1);
        end
    endtask

    task automatic add_row(input logic op, input logic [7:0] b, input logic [10:0] idx,
                           input fill_t fill, input logic typed, input logic [1:0] st,
                           input logic [10:0] len, input logic [7:0] rd,
                           input logic [31:0] fwd);
        vec_t r;
        r.op          = op;
        r.b           = b;
        r.idx         = idx;
        r.fill        = fill;
        r.typed       = typed;
        r.want.status = st;
        r.want.length = len;
        r.want.rdata  = rd;
        r.want.fwd    = fwd;
        directed_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        vec_t        r;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned n;
        int          cut;
        bit          big_done;
        bit          paused;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;
        row_typed     = 1'b0;
        row_want      = '0;
        wind_down     = 1'b0;
        beats_sent    = 0;
        steady_left   = 0;
        mismatch_cnt  = 0;
        frame_fill    = 0;
        fwd_total     = '0;
        big_done      = 1'b0;
        paused        = 1'b0;
        go_hunt();

        //      op       byte   index    fill            typed status      len  rd    fwd
        add_row(OP_READ, 8'h00, 11'd2047, FILL_NONE,     1'b1, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_NONE,     1'b1, ST_NONE,    '0, 8'h00, 32'd0);
        // reserved bits set drop the candidate
        add_row(OP_PUSH, 8'hD3, 11'd0,    FILL_NONE,     1'b1, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'hFC, 11'd2047, FILL_NONE,     1'b1, ST_HDR_BAD, '0, 8'h00, 32'd0);
        // a preamble in the header slot rejects and restarts in one go
        add_row(OP_PUSH, 8'hD3, 11'd0,    FILL_NONE,     1'b1, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'hD3, 11'd0,    FILL_NONE,     1'b1, ST_HDR_BAD, '0, 8'h00, 32'd0);
        // zero payload length
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_NONE,     1'b1, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_NONE,     1'b1, ST_HDR_BAD, '0, 8'h00, 32'd0);
        // shortest good frame, all-ones payload
        add_row(OP_PUSH, 8'hD3, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h01, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'hFF, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_CRC_HI,   1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_CRC_MID,  1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_CRC_LO,   1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        // shortest frame again, CRC spoiled in its top byte
        add_row(OP_PUSH, 8'hD3, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h01, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_CRC_SPOIL, 1'b0, ST_NONE,   '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_CRC_MID,  1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_PUSH, 8'h00, 11'd0,    FILL_CRC_LO,   1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        // buffer reads: first entry, last stored CRC byte, just past the end
        add_row(OP_READ, 8'hFF, 11'd0,    FILL_NONE,     1'b1, ST_NONE,    '0, 8'hD3, 32'd7);
        add_row(OP_READ, 8'h00, 11'd6,    FILL_NONE,     1'b0, ST_NONE,    '0, 8'h00, 32'd0);
        add_row(OP_READ, 8'h00, 11'd1030, FILL_NONE,     1'b1, ST_NONE,    '0, 8'h00, 32'd7);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the table. CRC bytes come from the model, which is current
        // here because the previous beat was taken at the last rising edge.
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            case (r.fill)
                FILL_CRC_HI:    b = crc_run[23:16];
                FILL_CRC_MID:   b = crc_run[15:8];
                FILL_CRC_LO:    b = crc_run[7:0];
                FILL_CRC_SPOIL: b = crc_run[23:16] ^ 8'h01;
                default:        b = r.b;
            endcase
            row_typed = r.typed;
            row_want  = r.want;
            push_beat(r.op, b, r.idx, 1'b1);
        end
        row_typed = 1'b0;

        // let the pipeline run dry once before the random traffic
        drain_reports();

        while (beats_sent < ITEMS)
        begin
            if (beats_sent >= ITEMS - CALM_TAIL)
                wind_down = 1'b1;
            if (!paused && beats_sent >= ITEMS / 2)
            begin
                drain_reports();
                paused = 1'b1;
            end
            if (!big_done && beats_sent >= 200)
            begin
                // longest frame the length field allows; fills all but the last buffer entry
                make_frame(10'd1023);
                send_frame(frame_bytes.size());
                big_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                make_frame(($urandom_range(0, 9) == 0) ? 10'($urandom_range(13, 60))
                                                       : 10'($urandom_range(1, 12)));
                send_frame(frame_bytes.size());
            end
            else if (pick < 65)
            begin
                // flip one bit in the CRC or in the payload
                make_frame(10'($urandom_range(1, 12)));
                if ($urandom_range(0, 1) == 0)
                    cut = frame_bytes.size() - 1 - $urandom_range(0, 2);
                else
                    cut = $urandom_range(3, frame_bytes.size() - 4);
                frame_bytes[cut] = frame_bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
                send_frame(frame_bytes.size());
            end
            else if (pick < 70)
            begin
                push_beat(OP_PUSH, PREAMBLE, 11'($urandom_range(0, 2047)), 1'b1);
                b = ($urandom_range(0, 3) == 0) ? PREAMBLE : 8'($urandom_range(4, 255));
                push_beat(OP_PUSH, b, 11'($urandom_range(0, 2047)), 1'b1);
            end
            else if (pick < 73)
            begin
                push_beat(OP_PUSH, PREAMBLE, 11'($urandom_range(0, 2047)), 1'b1);
                push_beat(OP_PUSH, 8'h00, 11'($urandom_range(0, 2047)), 1'b1);
                push_beat(OP_PUSH, 8'h00, 11'($urandom_range(0, 2047)), 1'b1);
            end
            else if (pick < 78)
            begin
                // cut a frame short; what follows is swallowed as its body
                make_frame(10'($urandom_range(1, 12)));
                send_frame($urandom_range(1, frame_bytes.size() - 1));
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    push_beat(OP_READ, 8'($urandom_range(0, 255)), pick_read_index(), 1'b1);
            end
            else
            begin
                // line noise between frames does not count as traffic
                n = $urandom_range(1, 6);
                repeat (n)
                    push_beat(OP_PUSH, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)), 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_cnt == 0 && expected_reports.size() == 0)
            $display("tb_rtcm3_frame_validator: done, clean");
        else
            $display("tb_rtcm3_frame_validator: done, errors");
        $finish;
    end

endmodule

[rtcm3_frame_validator.f]
design/rtcm3v_pkg.sv
design/rtcm3v_frame_ram.sv
design/rtcm3v_parser.sv
design/rtcm3v_out_queue.sv
design/rtcm3_frame_validator.sv
tb/tb_rtcm3_frame_validator.sv
